/* hdl/dgzz_pkg.sv */
// Shared types and constants for the diagonal zigzag matrix scan.
`timescale 1ns / 1ps
`default_nettype none

package dgzz_pkg;

   localparam int VALUE_W = 32;   // element width
   localparam int DIM_W   = 4;    // row/column count and index width
   localparam int DIAG_W  = 5;    // anti-diagonal index width
   localparam int COUNT_W = 7;    // load count width
   localparam int TOTAL_W = 8;    // rows * cols width
   localparam int OUT_IDX_W = 3;  // row/column index width on the result channel
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 4;
   localparam int RSP_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 2'd1;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef enum logic [1:0] {
      S_LOAD,
      S_FIX,
      S_SCAN
   } state_type;

endpackage

`default_nettype wire

/* hdl/dgzz_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module dgzz_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire                                         clock,
   input  wire                                         wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                            wr_data,
   input  wire                                         rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/diagonal_zigzag_matrix_scan.sv */
// Top level of the diagonal zigzag matrix scan: loader, sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   req_*  : one matrix element per transfer, in row-major order.
//   rsp_*  : every element of the matrix in zigzag anti-diagonal order, with its
//            row and column; rsp_tlast marks the final element of the run.
//   csr_*  : register writes (index 0 = rows, index 1 = columns, 4-bit values);
//            a count of zero acts as 1 and a count above the maximum saturates.
// Throughput: the transfer that completes the matrix starts the scan; each result
//   is read from the element RAM and then moved into the output register, and
//   one result leaves per cycle while rsp_tready stays high (one read port of
//   the element RAM sets that pace). req_tready drops for the scan, and no new
//   element is taken until the scan ends.
// After a register write outside the scan the load position is rebuilt by
//   repeated subtraction of the column count, with req_tready low.
// A stalled receiver holds the output register and freezes the RAM read; the
//   last result may still wait while new elements are taken.
// Reset (synchronous, active high) restores 8 x 8 and an empty load; the
// element RAM holds no reset value.

module diagonal_zigzag_matrix_scan #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // req_tdata: [31:0] element_value
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [dgzz_pkg::VALUE_W-1:0]         req_tdata,
   // rsp_tdata: [31:0] out_value, [34:32] out_row, [37:35] out_col, [39:38] zero
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [dgzz_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [dgzz_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [dgzz_pkg::CSR_DAT_W-1:0]       csr_data
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // largest count the 4-bit registers can reach after saturation
   localparam int ROW_LIM = (MAX_ROWS > 15) ? 15 : MAX_ROWS;
   localparam int COL_LIM = (MAX_COLS > 15) ? 15 : MAX_COLS;

   localparam int DW = dgzz_pkg::DIM_W;
   localparam int GW = dgzz_pkg::DIAG_W;
   localparam int CW = dgzz_pkg::COUNT_W;
   localparam int TW = dgzz_pkg::TOTAL_W;
   localparam int OW = dgzz_pkg::OUT_IDX_W;
   localparam int VW = dgzz_pkg::VALUE_W;

   // configuration
   logic [DW-1:0] rows_ff, cols_ff;
   logic [DW-1:0] rows_c, cols_c;
   logic [TW-1:0] total;

   // sequencer
   dgzz_pkg::state_type state_ff, state_in;

   // load position
   logic [CW-1:0] count_ff, rem_ff;
   logic [DW-1:0] ld_row_ff, ld_col_ff;

   // scan generator
   logic [GW-1:0] sd_ff;
   logic [DW-1:0] sr_ff, slo_ff, shi_ff;
   logic          gen_act_ff;

   // RAM read in flight and output register
   logic          pend_ff;
   logic [OW-1:0] pend_row_ff, pend_col_ff;
   logic          pend_last_ff;
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_value_ff;
   logic [OW-1:0] rsp_row_ff, rsp_col_ff;
   logic          rsp_last_ff;

   logic          csr_acc, req_acc, wrap, load_done;
   logic [CW-1:0] pos;
   logic [DW-1:0] wr_r, wr_c;
   logic          fix_skip, fix_sub;
   logic          out_free, move, issue;
   logic [DW-1:0] sc;
   logic          end_diag, gen_last;
   logic [GW-1:0] last_d, nd;
   logic [DW-1:0] nlo, nhi;
   logic [VW-1:0] ram_rd_data;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   // clamp the configured size
   always_comb begin
      if (rows_ff == '0) begin
         rows_c = DW'(1);
      end else if (rows_ff > DW'(ROW_LIM)) begin
         rows_c = DW'(ROW_LIM);
      end else begin
         rows_c = rows_ff;
      end
      if (cols_ff == '0) begin
         cols_c = DW'(1);
      end else if (cols_ff > DW'(COL_LIM)) begin
         cols_c = DW'(COL_LIM);
      end else begin
         cols_c = cols_ff;
      end
      total = TW'(rows_c) * TW'(cols_c);
   end

   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign req_acc   = req_tvalid && req_tready;

   // load position: restart when the count no longer fits the size
   assign wrap      = TW'(count_ff) >= total;
   assign pos       = wrap ? '0 : count_ff;
   assign wr_r      = wrap ? '0 : ld_row_ff;
   assign wr_c      = wrap ? '0 : ld_col_ff;
   assign load_done = (TW'(pos) + TW'(1)) == total;
   assign wr_addr   = ADDR_W'(int'(wr_r) * MAX_COLS + int'(wr_c));

   // position rebuild after a register write
   assign fix_skip = wrap;
   assign fix_sub  = rem_ff >= CW'(cols_c);

   // scan generator
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign move     = pend_ff && out_free;
   assign issue    = gen_act_ff && (!pend_ff || move);
   assign sc       = DW'(sd_ff - GW'(sr_ff));
   assign end_diag = sd_ff[0] ? (sr_ff == shi_ff) : (sr_ff == slo_ff);
   assign last_d   = GW'(rows_c) + GW'(cols_c) - GW'(2);
   assign gen_last = end_diag && (sd_ff == last_d);
   assign nd       = sd_ff + GW'(1);
   assign nlo      = (nd >= GW'(cols_c)) ? DW'(nd - GW'(cols_c) + GW'(1)) : '0;
   assign nhi      = (nd < GW'(rows_c - DW'(1))) ? DW'(nd) : (rows_c - DW'(1));
   assign rd_addr  = ADDR_W'(int'(sr_ff) * MAX_COLS + int'(sc));

   dgzz_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dgzz_pkg::S_LOAD: begin
            if (csr_acc) begin
               state_in = dgzz_pkg::S_FIX;
            end else if (req_acc && load_done) begin
               state_in = dgzz_pkg::S_SCAN;
            end
         end
         dgzz_pkg::S_FIX: begin
            if (csr_acc) begin
               state_in = dgzz_pkg::S_FIX;
            end else if (fix_skip || !fix_sub) begin
               state_in = dgzz_pkg::S_LOAD;
            end
         end
         dgzz_pkg::S_SCAN: begin
            if (!gen_act_ff && !pend_ff) begin
               state_in = dgzz_pkg::S_LOAD;
            end
         end
         default: state_in = dgzz_pkg::S_LOAD;
      endcase
   end

   // state outputs; a register write takes the cycle ahead of any element
   always_comb begin
      req_tready = 1'b0;
      unique case (state_ff)
         dgzz_pkg::S_LOAD: req_tready = !csr_valid;
         dgzz_pkg::S_FIX:  req_tready = 1'b0;
         dgzz_pkg::S_SCAN: req_tready = 1'b0;
         default:          req_tready = 1'b0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_col_ff, rsp_row_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dgzz_pkg::S_LOAD;
         rows_ff      <= dgzz_pkg::DIM_RESET;
         cols_ff      <= dgzz_pkg::DIM_RESET;
         count_ff     <= '0;
         ld_row_ff    <= '0;
         ld_col_ff    <= '0;
         gen_act_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_acc) begin
            unique case (csr_index)
               dgzz_pkg::CSR_NUM_ROWS: rows_ff <= csr_data;
               dgzz_pkg::CSR_NUM_COLS: cols_ff <= csr_data;
               default: ;
            endcase
         end

         // advance the load position
         if (req_acc) begin
            if (load_done) begin
               count_ff  <= '0;
               ld_row_ff <= '0;
               ld_col_ff <= '0;
            end else begin
               count_ff <= pos + CW'(1);
               if (wr_c + DW'(1) == cols_c) begin
                  ld_col_ff <= '0;
                  ld_row_ff <= wr_r + DW'(1);
               end else begin
                  ld_col_ff <= wr_c + DW'(1);
                  ld_row_ff <= wr_r;
               end
            end
         end else if (csr_acc && state_ff != dgzz_pkg::S_SCAN) begin
            ld_row_ff <= '0;
         end else if (state_ff == dgzz_pkg::S_FIX && !fix_skip) begin
            // rebuild row and column by subtracting the column count
            if (fix_sub) begin
               ld_row_ff <= ld_row_ff + DW'(1);
            end else begin
               ld_col_ff <= DW'(rem_ff);
            end
         end

         // generator activity
         if (req_acc && load_done) begin
            gen_act_ff <= 1'b1;
         end else if (issue && gen_last) begin
            gen_act_ff <= 1'b0;
         end

         if (issue) begin
            pend_ff <= 1'b1;
         end else if (move) begin
            pend_ff <= 1'b0;
         end

         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      if (csr_acc && state_ff != dgzz_pkg::S_SCAN) begin
         rem_ff <= count_ff;
      end else if (state_ff == dgzz_pkg::S_FIX && fix_sub) begin
         rem_ff <= rem_ff - CW'(cols_c);
      end

      if (req_acc && load_done) begin
         sd_ff  <= '0;
         sr_ff  <= '0;
         slo_ff <= '0;
         shi_ff <= '0;
      end else if (issue && !gen_last) begin
         if (end_diag) begin
            sd_ff  <= nd;
            slo_ff <= nlo;
            shi_ff <= nhi;
            sr_ff  <= nd[0] ? nlo : nhi;
         end else begin
            sr_ff <= sd_ff[0] ? (sr_ff + DW'(1)) : (sr_ff - DW'(1));
         end
      end

      if (issue) begin
         pend_row_ff  <= OW'(sr_ff);
         pend_col_ff  <= OW'(sc);
         pend_last_ff <= gen_last;
      end

      if (move) begin
         rsp_value_ff <= ram_rd_data;
         rsp_row_ff   <= pend_row_ff;
         rsp_col_ff   <= pend_col_ff;
         rsp_last_ff  <= pend_last_ff;
      end
   end

endmodule

`default_nettype wire
